// File: rtl/core/adts_dfr_pkg.sv
// shared types and constants of the adts stream deframer
package adts_dfr_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_TAG_CHECK = 3'd0,
    PH_TAG_SKIP  = 3'd1,
    PH_HUNT      = 3'd2,
    PH_CONFIRM   = 3'd3,
    PH_LOCKED    = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  // window and field geometry
  localparam int WIN_DEPTH = 10;
  localparam int HDR_BYTES = 6;
  localparam int POS_W     = 4;
  localparam int LEN_W     = 13;
  localparam int SKIP_W    = 29;
  localparam int SIZE_W    = 28;

  // sync word and header masks
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] SYNC_MASK    = 8'hF6;
  localparam logic [7:0] SYNC_MATCH   = 8'hF0;
  localparam logic [7:0] PROFILE_MASK = 8'hC0;
  localparam logic [7:0] RATE_MASK    = 8'h3C;

  // id3v2 tag constants
  localparam logic [7:0] ID3_CHAR_I   = 8'h49;
  localparam logic [7:0] ID3_CHAR_D   = 8'h44;
  localparam logic [7:0] ID3_CHAR_3   = 8'h33;
  localparam logic [7:0] FOOTER_BIT   = 8'h10;
  localparam logic [7:0] SYNCSAFE_LIM = 8'h80;
  localparam int         FOOTER_BYTES = 10;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 13'd7;

  // confirmation register
  localparam logic [1:0] CONFIRM_RESET = 2'd2;
  localparam logic [1:0] CONFIRM_MAX   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic [2:0]  channel_config;
    logic [31:0] frame_total;
    logic [31:0] frame_bytes_total;
    logic [31:0] audio_start;
    logic        tag_present;
  } result_t;

  // handshake between the core and the register stages
  typedef struct packed {
    logic item_valid;
    logic slot_free;
  } stage_status_t;

  typedef struct packed {
    logic advance;
    logic res_load;
  } core_ctrl_t;

endpackage

// File: rtl/core/adts_dfr_if.sv
// byte stream and result channel interfaces
interface adts_dfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface adts_dfr_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  profile;
  logic [3:0]  rate_index;
  logic [2:0]  channel_config;
  logic [31:0] frame_total;
  logic [31:0] frame_bytes_total;
  logic [31:0] audio_start;
  logic        tag_present;

  modport source (
    output valid, output found, output profile, output rate_index,
    output channel_config, output frame_total, output frame_bytes_total,
    output audio_start, output tag_present, input ready
  );
  modport sink (
    input valid, input found, input profile, input rate_index,
    input channel_config, input frame_total, input frame_bytes_total,
    input audio_start, input tag_present, output ready
  );
endinterface

// File: rtl/core/adts_dfr_in_stage.sv
// input register for the byte stream
module adts_dfr_in_stage import adts_dfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  adts_dfr_byte_if.sink         byte_stream,
  input  core_ctrl_t            ctrl,
  output logic                  item_valid,
  output byte_item_t            item
);

  logic take;

  assign byte_stream.ready = !item_valid || ctrl.advance;
  assign take              = byte_stream.valid && byte_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (ctrl.advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data_byte <= byte_stream.data_byte;
      item.last_byte <= byte_stream.last_byte;
    end
  end

endmodule

// File: rtl/core/adts_dfr_out_stage.sv
// result register for the end-of-stream report
module adts_dfr_out_stage import adts_dfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  core_ctrl_t            ctrl,
  input  result_t               res,
  output logic                  slot_free,
  adts_dfr_res_if.source        result
);

  logic    res_valid;
  result_t res_hold;

  assign slot_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      res_hold <= res;
    end
  end

  assign result.valid             = res_valid;
  assign result.found             = res_hold.found;
  assign result.profile           = res_hold.profile;
  assign result.rate_index        = res_hold.rate_index;
  assign result.channel_config    = res_hold.channel_config;
  assign result.frame_total       = res_hold.frame_total;
  assign result.frame_bytes_total = res_hold.frame_bytes_total;
  assign result.audio_start       = res_hold.audio_start;
  assign result.tag_present       = res_hold.tag_present;

endmodule

// File: rtl/core/adts_dfr_core.sv
// tag skip, sync hunt, header confirmation and frame counting
module adts_dfr_core import adts_dfr_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_wr_data,
  input  stage_status_t status,
  input  byte_item_t    item,
  output core_ctrl_t    ctrl,
  output result_t       res
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // registers
  phase_t                phase;
  logic [7:0]            win [WIN_DEPTH];
  logic [POS_W-1:0]      byte_pos;
  logic [SKIP_W-1:0]     skip_rem;
  logic [1:0]            first_profile;
  logic [3:0]            first_rate;
  logic [2:0]            first_chan;
  logic [1:0]            conf_seen;
  logic [COUNT_BITS-1:0] frames;
  logic [COUNT_BITS-1:0] bytes_sum;
  logic [COUNT_BITS-1:0] offset;
  logic [COUNT_BITS-1:0] start_offset;
  logic                  tag_seen;
  logic [1:0]            confirm_headers;

  // next values for one byte
  phase_t                phase_next;
  logic [7:0]            win_next [WIN_DEPTH];
  logic [POS_W-1:0]      byte_pos_next;
  logic [SKIP_W-1:0]     skip_rem_next;
  logic [1:0]            first_profile_next;
  logic [3:0]            first_rate_next;
  logic [2:0]            first_chan_next;
  logic [1:0]            conf_seen_next;
  logic [COUNT_BITS-1:0] frames_next;
  logic [COUNT_BITS-1:0] bytes_sum_next;
  logic [COUNT_BITS-1:0] offset_next;
  logic [COUNT_BITS-1:0] start_offset_next;
  logic                  tag_seen_next;

  // decode
  logic                  advance;
  logic                  last;
  logic                  take_byte;
  logic                  skip_zero;
  logic [SKIP_W-1:0]     skip_dec;
  logic [POS_W-1:0]      pos_inc;
  logic                  pos_full;
  logic                  pos_hdr;
  logic [1:0]            hdr_profile;
  logic [3:0]            hdr_rate;
  logic [2:0]            hdr_chan;
  logic [LEN_W-1:0]      hdr_len;
  logic                  hdr_sync;
  logic                  hunt_hit;
  logic                  hdr_match;
  logic                  tag_ok;
  logic [SIZE_W-1:0]     tag_size;
  logic [SKIP_W-1:0]     tag_skip;
  logic                  hunt_take;
  logic                  hdr_eval;
  logic                  conf_ok;
  logic                  count_ok;
  logic                  conf_fail;
  logic [1:0]            conf_inc;
  logic [1:0]            target;
  phase_t                lock_phase;
  logic [COUNT_BITS:0]   bytes_add;
  logic [COUNT_BITS-1:0] frames_inc;
  logic [COUNT_BITS-1:0] offset_inc;
  logic [SKIP_W-1:0]     frame_skip;

  assign last    = item.last_byte;
  assign advance = status.item_valid && (!last || status.slot_free);
  assign ctrl.advance  = advance;
  assign ctrl.res_load = advance && last;

  // shifted window, newest byte last
  always_comb begin
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[WIN_DEPTH-1] = item.data_byte;
  end

  assign skip_zero = (skip_rem == '0);
  assign skip_dec  = skip_zero ? skip_rem : skip_rem - 1'b1;
  assign take_byte = (phase == PH_TAG_CHECK) || (phase == PH_HUNT)
                  || (((phase == PH_CONFIRM) || (phase == PH_LOCKED)) && skip_zero);
  assign pos_full  = (byte_pos == POS_W'(WIN_DEPTH));
  assign pos_inc   = pos_full ? byte_pos : byte_pos + 1'b1;
  assign pos_hdr   = (pos_inc >= POS_W'(HDR_BYTES));

  // header fields from the last six bytes
  assign hdr_profile = 2'((win_next[6] & PROFILE_MASK) >> 6);
  assign hdr_rate    = 4'((win_next[6] & RATE_MASK) >> 2);
  assign hdr_chan    = {win_next[6][0], win_next[7][7:6]};
  assign hdr_len     = {win_next[7][1:0], win_next[8], win_next[9][7:5]};
  assign hdr_sync    = (win_next[4] == SYNC_BYTE)
                    && ((win_next[5] & SYNC_MASK) == SYNC_MATCH);
  assign hunt_hit    = hdr_sync && (hdr_len >= MIN_FRAME_LEN);
  assign hdr_match   = (hdr_profile == first_profile) && (hdr_rate == first_rate)
                    && (hdr_chan == first_chan);

  // id3v2 tag test over the full window
  assign tag_ok = (phase == PH_TAG_CHECK) && (pos_inc == POS_W'(WIN_DEPTH))
               && (win_next[0] == ID3_CHAR_I) && (win_next[1] == ID3_CHAR_D)
               && (win_next[2] == ID3_CHAR_3)
               && (win_next[3] != SYNC_BYTE) && (win_next[4] != SYNC_BYTE)
               && (win_next[6] < SYNCSAFE_LIM) && (win_next[7] < SYNCSAFE_LIM)
               && (win_next[8] < SYNCSAFE_LIM) && (win_next[9] < SYNCSAFE_LIM);
  assign tag_size = {win_next[6][6:0], win_next[7][6:0], win_next[8][6:0],
                     win_next[9][6:0]};
  assign tag_skip = SKIP_W'(tag_size)
                  + (((win_next[5] & FOOTER_BIT) != 8'h00) ? SKIP_W'(FOOTER_BYTES)
                                                           : SKIP_W'(0));

  assign hunt_take = ((phase == PH_TAG_CHECK) || (phase == PH_HUNT)) && pos_hdr
                  && !tag_ok && hunt_hit;
  assign hdr_eval  = ((phase == PH_CONFIRM) || (phase == PH_LOCKED)) && skip_zero
                  && pos_hdr;
  assign conf_ok   = hunt_hit && hdr_match;
  assign count_ok  = hdr_eval && ((phase == PH_CONFIRM) ? conf_ok : hunt_hit);
  assign conf_fail = hdr_eval && (phase == PH_CONFIRM) && !conf_ok;
  assign conf_inc  = conf_seen + 1'b1;
  // a setting of three behaves as two
  assign target    = (confirm_headers > CONFIRM_MAX) ? CONFIRM_MAX : confirm_headers;
  assign lock_phase = (target == 2'd0) ? PH_LOCKED : PH_CONFIRM;

  assign frames_inc = (frames == CNT_MAX) ? frames : frames + 1'b1;
  assign offset_inc = (offset == CNT_MAX) ? offset : offset + 1'b1;
  assign bytes_add  = {1'b0, bytes_sum} + (COUNT_BITS+1)'(hdr_len);
  assign frame_skip = SKIP_W'(hdr_len) - SKIP_W'(HDR_BYTES);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_TAG_CHECK: begin
        if (tag_ok) begin
          phase_next = (tag_skip != '0) ? PH_TAG_SKIP : PH_HUNT;
        end else if (hunt_take) begin
          phase_next = lock_phase;
        end else if (pos_inc == POS_W'(WIN_DEPTH)) begin
          phase_next = PH_HUNT;
        end
      end
      PH_TAG_SKIP: begin
        if (skip_dec == '0) begin
          phase_next = PH_HUNT;
        end
      end
      PH_HUNT: begin
        if (hunt_take) begin
          phase_next = lock_phase;
        end
      end
      PH_CONFIRM: begin
        if (conf_fail) begin
          phase_next = PH_HUNT;
        end else if (count_ok && (conf_inc >= target)) begin
          phase_next = PH_LOCKED;
        end
      end
      PH_LOCKED: begin
        if (hdr_eval && !hunt_hit) begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = phase;
    endcase
  end

  // datapath next values
  always_comb begin
    byte_pos_next      = byte_pos;
    skip_rem_next      = skip_rem;
    first_profile_next = first_profile;
    first_rate_next    = first_rate;
    first_chan_next    = first_chan;
    conf_seen_next     = conf_seen;
    frames_next        = frames;
    bytes_sum_next     = bytes_sum;
    start_offset_next  = start_offset;
    tag_seen_next      = tag_seen;
    offset_next        = offset_inc;

    if (take_byte) begin
      byte_pos_next = pos_inc;
    end
    if ((phase == PH_TAG_SKIP) || ((phase == PH_CONFIRM) || (phase == PH_LOCKED))) begin
      skip_rem_next = skip_dec;
    end
    if ((phase == PH_TAG_SKIP) && (skip_dec == '0)) begin
      byte_pos_next = '0;
    end
    if (tag_ok) begin
      tag_seen_next = 1'b1;
      skip_rem_next = tag_skip;
      byte_pos_next = '0;
    end
    if (hdr_eval) begin
      byte_pos_next = '0;
    end
    if (hunt_take) begin
      first_profile_next = hdr_profile;
      first_rate_next    = hdr_rate;
      first_chan_next    = hdr_chan;
      conf_seen_next     = '0;
      frames_next        = COUNT_BITS'(1);
      bytes_sum_next     = COUNT_BITS'(hdr_len);
      start_offset_next  = offset - COUNT_BITS'(HDR_BYTES - 1);
      skip_rem_next      = frame_skip;
      byte_pos_next      = '0;
    end
    if (count_ok) begin
      frames_next    = frames_inc;
      bytes_sum_next = bytes_add[COUNT_BITS] ? CNT_MAX : bytes_add[COUNT_BITS-1:0];
      skip_rem_next  = frame_skip;
      if (phase == PH_CONFIRM) begin
        conf_seen_next = conf_inc;
      end
    end
    if (conf_fail) begin
      first_profile_next = '0;
      first_rate_next    = '0;
      first_chan_next    = '0;
      conf_seen_next     = '0;
      frames_next        = '0;
      bytes_sum_next     = '0;
      start_offset_next  = '0;
    end
  end

  // end-of-stream report
  always_comb begin
    res.found = (phase_next == PH_CONFIRM) || (phase_next == PH_LOCKED)
             || (phase_next == PH_DONE);
    res.profile           = res.found ? first_profile_next : 2'd0;
    res.rate_index        = res.found ? first_rate_next : 4'd0;
    res.channel_config    = res.found ? first_chan_next : 3'd0;
    res.frame_total       = 32'(frames_next);
    res.frame_bytes_total = 32'(bytes_sum_next);
    res.audio_start       = res.found ? 32'(start_offset_next) : 32'd0;
    res.tag_present       = tag_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_headers <= CONFIRM_RESET;
    end else if (cfg_wr_en) begin
      confirm_headers <= cfg_wr_data;
    end
  end

  // a finished file puts the parser state back to its reset values; confirm_headers keeps its setting
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG_CHECK;
      byte_pos      <= '0;
      skip_rem      <= '0;
      first_profile <= '0;
      first_rate    <= '0;
      first_chan    <= '0;
      conf_seen     <= '0;
      frames        <= '0;
      bytes_sum     <= '0;
      offset        <= '0;
      start_offset  <= '0;
      tag_seen      <= 1'b0;
    end else if (advance) begin
      if (last) begin
        phase         <= PH_TAG_CHECK;
        byte_pos      <= '0;
        skip_rem      <= '0;
        first_profile <= '0;
        first_rate    <= '0;
        first_chan    <= '0;
        conf_seen     <= '0;
        frames        <= '0;
        bytes_sum     <= '0;
        offset        <= '0;
        start_offset  <= '0;
        tag_seen      <= 1'b0;
      end else begin
        phase         <= phase_next;
        byte_pos      <= byte_pos_next;
        skip_rem      <= skip_rem_next;
        first_profile <= first_profile_next;
        first_rate    <= first_rate_next;
        first_chan    <= first_chan_next;
        conf_seen     <= conf_seen_next;
        frames        <= frames_next;
        bytes_sum     <= bytes_sum_next;
        offset        <= offset_next;
        start_offset  <= start_offset_next;
        tag_seen      <= tag_seen_next;
      end
    end
  end

  // window bytes are only read once enough new bytes have arrived
  always_ff @(posedge clk) begin
    if (advance && take_byte) begin
      win <= win_next;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAG_SKIP) |-> (skip_rem != '0))
    else $error("tag skip phase with nothing left to skip");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= POS_W'(WIN_DEPTH))
    else $error("window fill count out of range");

  a_confirm_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CONFIRM) |-> (conf_seen < CONFIRM_MAX))
    else $error("confirmation count beyond target while confirming");

  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    ctrl.res_load |=> ((phase == PH_TAG_CHECK) && (offset == '0) && (frames == '0)))
    else $error("state not cleared after end of stream");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    ctrl.res_load |-> status.slot_free)
    else $error("result loaded while output register is occupied");

endmodule

// File: rtl/core/adts_stream_deframer_unit.sv
// top level of the adts stream deframer
//
//  channel      dir  handshake     payload
//  byte_stream  in   valid/ready   data_byte[7:0], last_byte
//  result       out  valid/ready   found, profile, rate_index, channel_config,
//                                  frame_total, frame_bytes_total, audio_start,
//                                  tag_present
//  cfg          in   cfg_wr_en     cfg_wr_data[1:0] (confirm_headers)
//
// one byte per cycle sustained, except that a file's last byte waits while
// the result register is occupied; each byte waits in the input register
// until the parser takes it; the report loads as a file's last byte is taken
// rst is synchronous; it clears the parser and sets confirm_headers to 2
// only the last byte waits on the result register; other bytes keep flowing
// while a report sits unclaimed on the result channel
module adts_stream_deframer_unit import adts_dfr_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  adts_dfr_byte_if.sink    byte_stream,
  adts_dfr_res_if.source   result,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data
);

  // status from the register stages, control from the parser
  stage_status_t status;
  core_ctrl_t    ctrl;
  byte_item_t    item;
  result_t       res;
  logic          item_valid;
  logic          slot_free;

  assign status.item_valid = item_valid;
  assign status.slot_free  = slot_free;

  // input register, refilled in the cycle that the parser takes a byte
  adts_dfr_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .ctrl        (ctrl),
    .item_valid  (item_valid),
    .item        (item)
  );

  // tag skip, sync hunt, confirmation and frame counting
  adts_dfr_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .item        (item),
    .ctrl        (ctrl),
    .res         (res)
  );

  // result register, one report per file
  adts_dfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .res       (res),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule

// File: tb/sv/tb.sv
// self-checking testbench of the adts stream deframer: byte files in, one report per file out
module tb import adts_dfr_pkg::*; ();

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  adts_dfr_byte_if bs();
  adts_dfr_res_if  rs();

  adts_stream_deframer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (bs),
    .result      (rs),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser mirror: follows the block byte by byte and queues the report that
  // each last byte must produce
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [7:0]  win [WIN_DEPTH];   // newest byte at the top index
  int          pos;               // count of valid window bytes, stops at 10
  logic [31:0] skip_left;         // bytes still to pass over (tag or frame body)
  logic [1:0]  f_prof;
  logic [3:0]  f_rate;
  logic [2:0]  f_chan;
  int          confirms;
  logic [31:0] frames;
  logic [31:0] fbytes;
  logic [31:0] offs;              // index of the next byte in the file
  logic [31:0] start_off;         // offset of the candidate first frame
  logic        tag_seen;
  logic [1:0]  confirm_reg;       // mirror of confirm_headers

  result_t     report_q [$];      // reports still owed by the block
  logic [7:0]  file_buf [$];      // file under construction

  // idling control
  bit gaps_on;
  int hold_left;                  // long result stall, counted down per cycle
  int stall_left;

  int mismatches;
  int reports_seen;
  int files_sent;
  int bytes_sent;

  result_t got_r;
  result_t want_r;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void clear_parser();
    ph = PH_TAG_CHECK;
    foreach (win[i]) win[i] = 8'h00;
    pos       = 0;
    skip_left = 0;
    f_prof    = 0;
    f_rate    = 0;
    f_chan    = 0;
    confirms  = 0;
    frames    = 0;
    fbytes    = 0;
    offs      = 0;
    start_off = 0;
    tag_seen  = 1'b0;
  endfunction

  function void shift_in(logic [7:0] b);
    for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i+1];
    win[WIN_DEPTH-1] = b;
    if (pos < WIN_DEPTH) pos++;
  endfunction

  // header occupies win[4..9]
  function automatic logic hdr_sync();
    return win[4] == SYNC_BYTE && (win[5] & SYNC_MASK) == SYNC_MATCH;
  endfunction

  function automatic logic [LEN_W-1:0] hdr_len();
    return {win[7][1:0], win[8], win[9][7:5]};
  endfunction

  function automatic int target_count();
    return (confirm_reg > CONFIRM_MAX) ? int'(CONFIRM_MAX) : int'(confirm_reg);
  endfunction

  function automatic logic id3_header_ok();
    return pos == WIN_DEPTH && win[0] == ID3_CHAR_I && win[1] == ID3_CHAR_D
        && win[2] == ID3_CHAR_3 && win[3] < 8'hFF && win[4] < 8'hFF
        && win[6] < SYNCSAFE_LIM && win[7] < SYNCSAFE_LIM
        && win[8] < SYNCSAFE_LIM && win[9] < SYNCSAFE_LIM;
  endfunction

  function void count_frame(logic [LEN_W-1:0] len);
    frames    = sat_add32(frames, 32'd1);
    fbytes    = sat_add32(fbytes, 32'(len));
    skip_left = 32'(len) - HDR_BYTES;
    pos       = 0;
  endfunction

  function void try_hunt();
    logic [LEN_W-1:0] len;
    len = hdr_len();
    if (!hdr_sync() || len < MIN_FRAME_LEN) return;
    f_prof    = win[6][7:6];
    f_rate    = win[6][5:2];
    f_chan    = {win[6][0], win[7][7:6]};
    frames    = 0;
    fbytes    = 0;
    start_off = offs - 32'd5;
    confirms  = 0;
    count_frame(len);
    if (target_count() == 0) ph = PH_LOCKED;
    else ph = PH_CONFIRM;
  endfunction

  function void check_confirm();
    logic [LEN_W-1:0] len;
    logic             ok;
    len = hdr_len();
    ok  = hdr_sync() && len >= MIN_FRAME_LEN && win[6][7:6] == f_prof
       && win[6][5:2] == f_rate && {win[6][0], win[7][7:6]} == f_chan;
    pos = 0;
    if (!ok) begin
      // failed confirmation drops the candidate and hunts on from here
      frames    = 0;
      fbytes    = 0;
      f_prof    = 0;
      f_rate    = 0;
      f_chan    = 0;
      confirms  = 0;
      start_off = 0;
      ph        = PH_HUNT;
    end else begin
      count_frame(len);
      confirms++;
      if (confirms >= target_count()) ph = PH_LOCKED;
    end
  endfunction

  function void check_locked();
    logic [LEN_W-1:0] len;
    len = hdr_len();
    pos = 0;
    if (hdr_sync() && len >= MIN_FRAME_LEN) count_frame(len);
    else ph = PH_DONE;
  endfunction

  function void parse_byte(logic [7:0] b, logic last);
    logic [31:0] sz;
    logic        hit;
    result_t     r;
    case (ph)
      PH_TAG_CHECK: begin
        shift_in(b);
        if (id3_header_ok()) begin
          sz = {4'd0, win[6][6:0], win[7][6:0], win[8][6:0], win[9][6:0]};
          if ((win[5] & FOOTER_BIT) != 0) sz = sz + FOOTER_BYTES;
          tag_seen  = 1'b1;
          skip_left = sz;
          pos       = 0;
          if (sz != 0) ph = PH_TAG_SKIP;
          else ph = PH_HUNT;
        end else begin
          // the hunt already slides over the first ten bytes
          if (pos == WIN_DEPTH) ph = PH_HUNT;
          if (pos >= HDR_BYTES) try_hunt();
        end
      end
      PH_TAG_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          pos = 0;
          ph  = PH_HUNT;
        end
      end
      PH_HUNT: begin
        shift_in(b);
        if (pos >= HDR_BYTES) try_hunt();
      end
      PH_CONFIRM, PH_LOCKED: begin
        if (skip_left > 0) begin
          skip_left--;
        end else begin
          shift_in(b);
          if (pos >= HDR_BYTES) begin
            if (ph == PH_CONFIRM) check_confirm();
            else check_locked();
          end
        end
      end
      default: ;
    endcase
    offs = sat_add32(offs, 32'd1);
    if (last) begin
      hit                 = (ph == PH_CONFIRM || ph == PH_LOCKED || ph == PH_DONE);
      r.found             = hit;
      r.profile           = hit ? f_prof : 2'd0;
      r.rate_index        = hit ? f_rate : 4'd0;
      r.channel_config    = hit ? f_chan : 3'd0;
      r.frame_total       = frames;
      r.frame_bytes_total = fbytes;
      r.audio_start       = hit ? start_off : 32'd0;
      r.tag_present       = tag_seen;
      report_q.push_back(r);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // file builders
  // ---------------------------------------------------------------------------
  function void add_junk(int n);
    repeat (n) file_buf.push_back(8'($urandom));
  endfunction

  // six header bytes; the bits outside the sync mask and the spare bits are random
  function void add_header(logic [1:0] p, logic [3:0] r, logic [2:0] c,
                           logic [LEN_W-1:0] len);
    file_buf.push_back(SYNC_BYTE);
    file_buf.push_back(SYNC_MATCH | (8'($urandom) & ~SYNC_MASK));
    file_buf.push_back({p, r, 1'($urandom), c[2]});
    file_buf.push_back({c[1:0], 4'($urandom), len[12:11]});
    file_buf.push_back(len[10:3]);
    file_buf.push_back({len[2:0], 5'($urandom)});
  endfunction

  function void add_frame(logic [1:0] p, logic [3:0] r, logic [2:0] c,
                          logic [LEN_W-1:0] len);
    add_header(p, r, c, len);
    if (len > HDR_BYTES) add_junk(int'(len) - HDR_BYTES);
  endfunction

  // id3v2 tag with a syncsafe size and its body
  function void add_tag(int size, bit footer);
    logic [27:0] sz;
    sz = 28'(size);
    file_buf.push_back(ID3_CHAR_I);
    file_buf.push_back(ID3_CHAR_D);
    file_buf.push_back(ID3_CHAR_3);
    file_buf.push_back(8'($urandom_range(0, 254)));
    file_buf.push_back(8'($urandom_range(0, 254)));
    file_buf.push_back(footer ? (8'($urandom) | FOOTER_BIT) : (8'($urandom) & ~FOOTER_BIT));
    file_buf.push_back({1'b0, sz[27:21]});
    file_buf.push_back({1'b0, sz[20:14]});
    file_buf.push_back({1'b0, sz[13:7]});
    file_buf.push_back({1'b0, sz[6:0]});
    add_junk(size + (footer ? FOOTER_BYTES : 0));
  endfunction

  // ---------------------------------------------------------------------------
  // byte sender: one transfer per call, random gap bursts ahead of it
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input logic l);
    int gap;
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 8);
      bs.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bs.valid     <= 1'b1;
    bs.data_byte <= d;
    bs.last_byte <= l;
    do @(posedge clk); while (!bs.ready);
    parse_byte(d, l);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_buf[i]) push_byte(file_buf[i], i == file_buf.size() - 1);
    files_sent++;
    file_buf.delete();
  endtask

  // register writes only with the block drained and quiet
  task automatic write_cfg(input logic [1:0] v);
    bs.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    confirm_reg = v;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random stall bursts and the long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rs.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rs.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      rs.ready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rs.ready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      rs.ready <= 1'b1;
    end
  end

  function automatic string fmt_report(result_t v);
    return $sformatf("found=%0d prof=%0d rate=%0d chan=%0d frames=%0d bytes=%0d start=%0d tag=%0d",
                     v.found, v.profile, v.rate_index, v.channel_config, v.frame_total,
                     v.frame_bytes_total, v.audio_start, v.tag_present);
  endfunction

  // every result transfer is compared with the oldest owed report
  always @(posedge clk) begin
    if (!rst && rs.valid && rs.ready) begin
      got_r = {rs.found, rs.profile, rs.rate_index, rs.channel_config, rs.frame_total,
               rs.frame_bytes_total, rs.audio_start, rs.tag_present};
      reports_seen++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report: %s", fmt_report(got_r));
      end else begin
        want_r = report_q.pop_front();
        if (got_r !== want_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch, expected: %s", fmt_report(want_r));
            $display("report mismatch, actual:   %s", fmt_report(got_r));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // files too short for the tag test, one of them still holding a header
  task automatic test_short_files();
    file_buf.push_back(SYNC_BYTE);
    send_file();
    add_junk(9);
    send_file();
    add_junk(2);
    add_header(2'd1, 4'd4, 3'd2, 13'd9);
    add_junk(1);
    send_file();
  endtask

  // tag with footer, empty tag, two broken tags and a file ending inside a tag
  task automatic test_tag_skip();
    add_tag(3, 1'b1);
    repeat (3) add_frame(2'd1, 4'd3, 3'd2, 13'd7);
    send_file();
    add_tag(0, 1'b0);
    repeat (3) add_frame(2'd2, 4'd8, 3'd1, 13'd8);
    send_file();
    // size byte above the syncsafe limit: not a tag
    add_tag(2, 1'b0);
    file_buf[6] = SYNCSAFE_LIM;
    repeat (3) add_frame(2'd0, 4'd5, 3'd6, 13'd7);
    send_file();
    add_tag(2, 1'b0);
    file_buf[3] = 8'hFF;
    add_frame(2'd3, 4'd1, 3'd3, 13'd7);
    send_file();
    add_tag(20, 1'b0);
    repeat (15) void'(file_buf.pop_back());
    send_file();
  endtask

  // short length while hunting, failed confirmation, end while confirming
  task automatic test_hunt_confirm();
    add_junk(3);
    add_header(2'd1, 4'd2, 3'd3, 13'd5);
    add_frame(2'd1, 4'd2, 3'd3, 13'd9);
    add_frame(2'd1, 4'd2, 3'd4, 13'd9);
    repeat (3) add_frame(2'd1, 4'd2, 3'd3, 13'd10);
    send_file();
    add_junk(2);
    add_frame(2'd2, 4'd6, 3'd1, 13'd8);
    add_junk(4);
    send_file();
    // short length as the confirming header
    add_frame(2'd2, 4'd6, 3'd1, 13'd8);
    add_header(2'd2, 4'd6, 3'd1, 13'd3);
    add_junk(3);
    send_file();
  endtask

  // locked stream that loses sync by a bad sync word and by a short length
  task automatic test_lost_sync();
    repeat (4) add_frame(2'd1, 4'd11, 3'd2, 13'd7);
    add_junk(6);
    add_frame(2'd1, 4'd11, 3'd2, 13'd7);
    send_file();
    repeat (3) add_frame(2'd0, 4'd3, 3'd5, 13'd8);
    add_header(2'd0, 4'd3, 3'd5, 13'd6);
    add_frame(2'd0, 4'd3, 3'd5, 13'd8);
    send_file();
  endtask

  // all-ones and all-zero header fields; the longest frame ends the file early
  task automatic test_field_extremes();
    add_junk(1);
    add_header(2'd3, 4'd15, 3'd7, 13'h1FFF);
    add_junk(10);
    send_file();
    repeat (3) add_frame(2'd0, 4'd0, 3'd0, 13'd7);
    send_file();
  endtask

  // confirm_headers 0, 1, 3 and then 2 again against the same kind of file
  task automatic test_confirm_settings();
    logic [1:0] v;
    for (int k = 0; k < 4; k++) begin
      v = (k == 3) ? CONFIRM_RESET : 2'(k == 2 ? 3 : k);
      write_cfg(v);
      add_frame(2'd1, 4'd7, 3'd2, 13'd7);
      add_frame(2'd1, 4'd7, 3'd2, 13'd8);
      add_frame(2'd1, 4'd9, 3'd2, 13'd7);
      add_frame(2'd1, 4'd7, 3'd2, 13'd7);
      send_file();
    end
  endtask

  // result side held off while short files keep coming, so input stalls
  task automatic test_backpressure();
    gaps_on   = 0;
    hold_left = 80;
    repeat (5) begin
      add_junk(2);
      file_buf.push_back(SYNC_BYTE);
      send_file();
    end
  endtask

  function void build_random_file();
    logic [1:0] p;
    logic [3:0] r;
    logic [2:0] c;
    int         nframes;
    int         cut;
    if ($urandom_range(0, 9) == 0) begin
      add_junk($urandom_range(1, 14));
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      add_tag($urandom_range(0, 6), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) file_buf[$urandom_range(0, 9)] = 8'($urandom);
    end
    add_junk($urandom_range(0, 4));
    p       = 2'($urandom);
    r       = 4'($urandom);
    c       = 3'($urandom);
    nframes = $urandom_range(1, 3);
    repeat (nframes) begin
      case ($urandom_range(0, 14))
        0: add_frame(p ^ 2'($urandom_range(1, 3)), r, c, 13'($urandom_range(7, 14)));
        1: add_frame(p, r ^ 4'($urandom_range(1, 15)), c, 13'($urandom_range(7, 14)));
        2: add_frame(p, r, c ^ 3'($urandom_range(1, 7)), 13'($urandom_range(7, 14)));
        3: add_header(p, r, c, 13'($urandom_range(0, 6)));
        4: add_junk($urandom_range(1, 6));
        default: add_frame(p, r, c, 13'($urandom_range(7, 14)));
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, 5);
      while (cut > 0 && file_buf.size() > 1) begin
        void'(file_buf.pop_back());
        cut--;
      end
    end else begin
      add_junk($urandom_range(0, 3));
    end
    if (file_buf.size() == 0) add_junk(1);
  endfunction

  // mostly well-formed files with random content; quiet handshakes at the end
  task automatic test_random_files();
    for (int n = 0; n < 4; n++) begin
      if (n % 2 == 0) write_cfg(2'($urandom_range(0, 3)));
      gaps_on = (n < 2);
      build_random_file();
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 2'd0;
    bs.valid     <= 1'b0;
    bs.data_byte <= 8'h00;
    bs.last_byte <= 1'b0;
    gaps_on      = 0;
    hold_left    = 0;
    stall_left   = 0;
    mismatches   = 0;
    reports_seen = 0;
    files_sent   = 0;
    bytes_sent   = 0;
    confirm_reg  = CONFIRM_RESET;
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed files run at the reset value of confirm_headers first
    test_short_files();
    gaps_on = 1;
    test_tag_skip();
    test_hunt_confirm();
    gaps_on = 0;
    test_lost_sync();
    gaps_on = 1;
    test_field_extremes();
    test_confirm_settings();
    test_backpressure();
    test_random_files();

    // drain: every owed report, then a quiet spell for stray ones
    bs.valid <= 1'b0;
    gaps_on = 0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d files, %0d bytes, %0d reports checked, %0d bad",
             files_sent, bytes_sent, reports_seen, mismatches);
    $display("summary: id3 tags, hunt, confirm, lock and lost sync under all four settings");
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/core/adts_dfr_pkg.sv
rtl/core/adts_dfr_if.sv
rtl/core/adts_dfr_in_stage.sv
rtl/core/adts_dfr_out_stage.sv
rtl/core/adts_dfr_core.sv
rtl/core/adts_stream_deframer_unit.sv
tb/sv/tb.sv
